// File: sv/tss_pkg.sv
// Package for the tone and scale sequencer: request/result payload types,
// request and status codes, and duty arithmetic constants. No dependencies.
package tss_pkg;

  localparam int unsigned MaxNotesDefault = 32;
  localparam int unsigned MaxNotesLimit   = 256;

  localparam logic [4:0]  ResBitsReset  = 5'd8;
  localparam logic [4:0]  ResBitsMax    = 5'd16;
  localparam logic [13:0] DutyFullScale = 14'd10000;

  // floor(p / 10000) == (p * RecipMult) >> RecipShift for every p < 2^30
  localparam logic [30:0] RecipMult  = 31'd1759218605;
  localparam int unsigned RecipShift = 44;

  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_TONE_DUTY   = 3'd1,
    REQ_TONE_HALF   = 3'd2,
    REQ_LOAD_NOTE   = 3'd3,
    REQ_START_SCALE = 3'd4,
    REQ_STOP        = 3'd5
  } tss_req_e;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_STARTED   = 3'd1,
    ST_REJ_BUSY  = 3'd2,
    ST_REJ_EMPTY = 3'd3,
    ST_TONE_END  = 3'd4,
    ST_NOTE_ADV  = 3'd5,
    ST_SCALE_END = 3'd6
  } tss_status_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] frequency_hz;
    logic [13:0] duty_hundredths;
    logic [31:0] duration_ms;
    logic [4:0]  note_slot;
    logic [5:0]  note_count;
    logic        direction_up;
  } tss_req_t;

  typedef struct packed {
    logic [15:0] out_frequency;
    logic [15:0] out_duty;
    logic        tone_busy;
    logic        scale_busy;
    logic [4:0]  current_note;
    logic [2:0]  status;
  } tss_res_t;

endpackage

// File: sv/tss_if.sv
// Valid/ready channel interfaces of the tone and scale sequencer.
// Depends on tss_pkg for the payload types.
interface tss_req_if;
  import tss_pkg::*;
  logic     valid;
  logic     ready;
  tss_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tss_res_if;
  import tss_pkg::*;
  logic     valid;
  logic     ready;
  tss_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tss_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/tss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tss_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tone_and_scale_sequencer.sv
// Tone and scale sequencer: turns tick, tone, note-load, scale and stop requests
// into PWM frequency/duty values. Depends on tss_pkg, tss_if.sv and tss_ram.
//
// One request is taken every clock cycle unless the result side stalls. Each
// produces exactly one result via both stages. The first stage updates the
// control state, issues the note table read and forms the duty product; the
// second stage holds the registered note table read data and the reciprocal
// multiply that divides the duty product by 10000. The resolution register may be
// written at any time the block is idle; its write channel is always ready.
module tone_and_scale_sequencer #(
  parameter int unsigned MaxNotes = tss_pkg::MaxNotesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  tss_cfg_if.sink   cfg_i,
  tss_req_if.sink   req_i,
  tss_res_if.source res_o
);
  import tss_pkg::*;

  localparam int unsigned PosW = (MaxNotes > 1) ? $clog2(MaxNotes) : 1;
  localparam int unsigned CntW = $clog2(MaxNotes + 1);

  typedef enum logic [2:0] {
    ACT_KEEP,
    ACT_SILENCE,
    ACT_TONE_CALC,
    ACT_TONE_HALF,
    ACT_NOTE
  } act_e;

  // control state
  logic [4:0]      res_bits_q;
  logic            tone_q, tone_d;
  logic            scale_q, scale_d;
  logic [31:0]     elapsed_q, elapsed_d;
  logic [31:0]     period_q, period_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [CntW-1:0] total_q, total_d;
  logic            asc_q, asc_d;

  // first stage
  logic            s1_valid_q;
  act_e            s1_act_q, act_d;
  logic [15:0]     s1_freq_q;
  logic [15:0]     s1_half_q;
  logic [29:0]     s1_prod_q;
  logic            s1_tone_q;
  logic            s1_scale_q;
  logic [4:0]      s1_note_q;
  tss_status_e     s1_status_q, status_d;

  // result register
  logic            res_valid_q;
  tss_res_t        res_q;

  logic            accept, s1_adv, busy, at_end, ram_we, ram_re;
  tss_req_t        rq;
  logic [4:0]      bits_eff;
  logic [15:0]     max_duty, half_duty;
  logic [13:0]     hund_c;
  logic [29:0]     prod;
  logic [31:0]     elapsed_inc;
  logic [8:0]      cnt_c, pos_ext;
  logic [15:0]     ram_rdata;
  logic [60:0]     recip_prod;
  logic [15:0]     duty_calc;

  assign rq       = req_i.data;
  assign s1_adv   = s1_valid_q && (!res_valid_q || res_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign accept   = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign busy     = tone_q || scale_q;

  always_comb begin
    if (res_bits_q == 5'd0) begin
      bits_eff = 5'd1;
    end else if (res_bits_q > ResBitsMax) begin
      bits_eff = ResBitsMax;
    end else begin
      bits_eff = res_bits_q;
    end
  end

  assign max_duty  = 16'((17'(1) << bits_eff) - 17'(1));
  assign half_duty = 16'(17'(1) << (bits_eff - 5'd1));
  assign hund_c    = (rq.duty_hundredths > DutyFullScale) ? DutyFullScale
                                                          : rq.duty_hundredths;
  assign prod      = 30'(max_duty) * 30'(hund_c);

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
  assign at_end = asc_q ? ((9'(pos_q) + 9'd1) >= 9'(total_q)) : (pos_q == '0);
  assign cnt_c  = (9'(rq.note_count) > 9'(MaxNotes)) ? 9'(MaxNotes) : 9'(rq.note_count);

  always_comb begin
    tone_d    = tone_q;
    scale_d   = scale_q;
    elapsed_d = elapsed_q;
    period_d  = period_q;
    pos_d     = pos_q;
    total_d   = total_q;
    asc_d     = asc_q;
    act_d     = ACT_KEEP;
    status_d  = ST_NONE;
    ram_we    = 1'b0;
    unique case (tss_req_e'(rq.req_type))
      REQ_TICK: begin
        if (busy) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= period_q) begin
            if (tone_q || at_end) begin
              tone_d   = 1'b0;
              scale_d  = 1'b0;
              act_d    = ACT_SILENCE;
              status_d = tone_q ? ST_TONE_END : ST_SCALE_END;
            end else begin
              pos_d     = asc_q ? pos_q + PosW'(1) : pos_q - PosW'(1);
              elapsed_d = '0;
              act_d     = ACT_NOTE;
              status_d  = ST_NOTE_ADV;
            end
          end
        end
      end
      REQ_TONE_DUTY, REQ_TONE_HALF: begin
        if (busy) begin
          status_d = ST_REJ_BUSY;
        end else begin
          period_d  = rq.duration_ms;
          elapsed_d = '0;
          tone_d    = 1'b1;
          act_d     = (tss_req_e'(rq.req_type) == REQ_TONE_DUTY) ? ACT_TONE_CALC
                                                                 : ACT_TONE_HALF;
          status_d  = ST_STARTED;
        end
      end
      REQ_LOAD_NOTE: begin
        ram_we = 9'(rq.note_slot) < 9'(MaxNotes);
      end
      REQ_START_SCALE: begin
        if (busy) begin
          status_d = ST_REJ_BUSY;
        end else if (rq.note_count == '0) begin
          status_d = ST_REJ_EMPTY;
        end else begin
          total_d   = CntW'(cnt_c);
          period_d  = rq.duration_ms;
          asc_d     = rq.direction_up;
          pos_d     = rq.direction_up ? '0 : PosW'(cnt_c - 9'd1);
          scale_d   = 1'b1;
          elapsed_d = '0;
          act_d     = ACT_NOTE;
          status_d  = ST_STARTED;
        end
      end
      REQ_STOP: begin
        if (tone_q) begin
          status_d = ST_TONE_END;
        end else if (scale_q) begin
          status_d = ST_SCALE_END;
        end
        tone_d  = 1'b0;
        scale_d = 1'b0;
        act_d   = ACT_SILENCE;
      end
      default: begin
      end
    endcase
  end

  assign ram_re  = accept && (act_d == ACT_NOTE);
  assign pos_ext = 9'(pos_d);

  tss_ram #(
    .Width (16),
    .Depth (MaxNotes)
  ) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (accept && ram_we),
    .waddr_i (PosW'(rq.note_slot)),
    .wdata_i (rq.frequency_hz),
    .re_i    (ram_re),
    .raddr_i (pos_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bits_q <= ResBitsReset;
      tone_q     <= 1'b0;
      scale_q    <= 1'b0;
      elapsed_q  <= '0;
      period_q   <= '0;
      pos_q      <= '0;
      total_q    <= '0;
      asc_q      <= 1'b1;
    end else begin
      if (cfg_i.valid) begin
        res_bits_q <= cfg_i.data;
      end
      if (accept) begin
        tone_q    <= tone_d;
        scale_q   <= scale_d;
        elapsed_q <= elapsed_d;
        period_q  <= period_d;
        pos_q     <= pos_d;
        total_q   <= total_d;
        asc_q     <= asc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_act_q    <= act_d;
      s1_freq_q   <= rq.frequency_hz;
      s1_half_q   <= half_duty;
      s1_prod_q   <= prod;
      s1_tone_q   <= tone_d;
      s1_scale_q  <= scale_d;
      s1_note_q   <= scale_d ? pos_ext[4:0] : 5'd0;
      s1_status_q <= status_d;
    end
  end

  assign recip_prod = 61'(s1_prod_q) * 61'(RecipMult);
  assign duty_calc  = recip_prod[RecipShift+15:RecipShift];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (s1_adv) begin
        res_valid_q        <= 1'b1;
        res_q.tone_busy    <= s1_tone_q;
        res_q.scale_busy   <= s1_scale_q;
        res_q.current_note <= s1_note_q;
        res_q.status       <= s1_status_q;
        unique case (s1_act_q)
          ACT_KEEP: begin
          end
          ACT_SILENCE: begin
            res_q.out_frequency <= '0;
            res_q.out_duty      <= '0;
          end
          ACT_TONE_CALC: begin
            res_q.out_frequency <= s1_freq_q;
            res_q.out_duty      <= duty_calc;
          end
          ACT_TONE_HALF: begin
            res_q.out_frequency <= s1_freq_q;
            res_q.out_duty      <= s1_half_q;
          end
          ACT_NOTE: begin
            res_q.out_frequency <= ram_rdata;
            res_q.out_duty      <= s1_half_q;
          end
          default: begin
          end
        endcase
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  a_one_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tone_q && scale_q))
    else $error("tone and scale both active");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_q |-> (9'(pos_q) < 9'(total_q)))
    else $error("note position beyond scale length");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("stage one item dropped while stalled");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && busy && (tss_req_e'(rq.req_type) == REQ_START_SCALE ||
      tss_req_e'(rq.req_type) == REQ_TONE_DUTY ||
      tss_req_e'(rq.req_type) == REQ_TONE_HALF))
    |=> ($stable(tone_q) && $stable(scale_q) && $stable(period_q)))
    else $error("rejected start changed state");

  a_advance_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.status == ST_NOTE_ADV) |-> res_q.scale_busy)
    else $error("note advance reported without a scale");

endmodule

// File: tb/tone_and_scale_sequencer_tb.sv
// Self-checking testbench for tone_and_scale_sequencer: drives requests and resolution
// writes over valid/ready channels, predicts each result in-bench and compares in order.
// Depends on tss_pkg and the channel interfaces in tss_if.sv.
`timescale 1ns / 100ps

module tone_and_scale_sequencer_tb;
  import tss_pkg::*;

  localparam int unsigned NoteSlots  = MaxNotesDefault;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ShowErrors = 10;
  localparam int unsigned StallLen   = 300;
  localparam int unsigned TickGuard  = 70;
  localparam logic [2:0]  ReqUnusedLo = 3'd6;
  localparam logic [2:0]  ReqUnusedHi = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  tss_cfg_if cfg_if ();
  tss_req_if req_if ();
  tss_res_if res_if ();

  tone_and_scale_sequencer u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #6 clk = ~clk;

  // predicted sequencer state
  logic [4:0]  seq_res_bits = ResBitsReset;
  logic [15:0] seq_notes [NoteSlots];
  logic        seq_tone_on  = 1'b0;
  logic        seq_scale_on = 1'b0;
  logic [31:0] seq_elapsed  = '0;
  logic [31:0] seq_period   = '0;
  logic [5:0]  seq_pos      = '0;
  logic [5:0]  seq_total    = '0;
  logic        seq_up       = 1'b1;
  logic [15:0] seq_freq     = '0;
  logic [15:0] seq_duty     = '0;

  tss_res_t drive_q [$];

  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  int unsigned stall_left   = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  int unsigned res_settings = 0;
  int unsigned tones_started  = 0;
  int unsigned scales_started = 0;

  function automatic logic [4:0] eff_res_bits();
    if (seq_res_bits == 5'd0) return 5'd1;
    if (seq_res_bits > ResBitsMax) return ResBitsMax;
    return seq_res_bits;
  endfunction

  function automatic logic [15:0] half_duty();
    return 16'(32'd1 << (eff_res_bits() - 5'd1));
  endfunction

  function automatic void go_silent();
    seq_freq     = '0;
    seq_duty     = '0;
    seq_tone_on  = 1'b0;
    seq_scale_on = 1'b0;
  endfunction

  function automatic void play_note();
    seq_freq    = seq_notes[seq_pos[4:0]];
    seq_duty    = half_duty();
    seq_elapsed = '0;
  endfunction

  function automatic tss_res_t sequencer_step(tss_req_t r);
    tss_res_t    o;
    tss_status_e st;
    logic        busy;
    logic        last;
    logic [13:0] hund;
    logic [31:0] prod;
    logic [5:0]  cnt;
    st   = ST_NONE;
    busy = seq_tone_on || seq_scale_on;
    case (r.req_type)
      REQ_TICK: begin
        if (busy) begin
          if (seq_elapsed != 32'hFFFF_FFFF) seq_elapsed++;
          if (seq_elapsed >= seq_period) begin
            last = seq_up ? (seq_pos + 6'd1 >= seq_total) : (seq_pos == 6'd0);
            if (seq_tone_on) begin
              go_silent();
              st = ST_TONE_END;
            end else if (last) begin
              go_silent();
              st = ST_SCALE_END;
            end else begin
              seq_pos = seq_up ? seq_pos + 6'd1 : seq_pos - 6'd1;
              play_note();
              st = ST_NOTE_ADV;
            end
          end
        end
      end
      REQ_TONE_DUTY, REQ_TONE_HALF: begin
        if (busy) begin
          st = ST_REJ_BUSY;
        end else begin
          if (r.req_type == REQ_TONE_DUTY) begin
            hund = (r.duty_hundredths > DutyFullScale) ? DutyFullScale : r.duty_hundredths;
            prod = ((32'd1 << eff_res_bits()) - 32'd1) * 32'(hund);
            seq_duty = 16'(prod / 32'(DutyFullScale));
          end else begin
            seq_duty = half_duty();
          end
          seq_freq    = r.frequency_hz;
          seq_period  = r.duration_ms;
          seq_elapsed = '0;
          seq_tone_on = 1'b1;
          st = ST_STARTED;
        end
      end
      REQ_LOAD_NOTE: begin
        if (r.note_slot < NoteSlots) seq_notes[r.note_slot] = r.frequency_hz;
      end
      REQ_START_SCALE: begin
        if (busy) begin
          st = ST_REJ_BUSY;
        end else if (r.note_count == 6'd0) begin
          st = ST_REJ_EMPTY;
        end else begin
          cnt = (r.note_count > NoteSlots) ? 6'(NoteSlots) : r.note_count;
          seq_total    = cnt;
          seq_period   = r.duration_ms;
          seq_up       = r.direction_up;
          seq_pos      = r.direction_up ? 6'd0 : cnt - 6'd1;
          seq_scale_on = 1'b1;
          play_note();
          st = ST_STARTED;
        end
      end
      REQ_STOP: begin
        if (seq_tone_on) st = ST_TONE_END;
        else if (seq_scale_on) st = ST_SCALE_END;
        go_silent();
      end
      default: ;
    endcase
    o.out_frequency = seq_freq;
    o.out_duty      = seq_duty;
    o.tone_busy     = seq_tone_on;
    o.scale_busy    = seq_scale_on;
    o.current_note  = seq_scale_on ? seq_pos[4:0] : 5'd0;
    o.status        = st;
    return o;
  endfunction

  function automatic void log_failure(string msg);
    errors++;
    if (errors <= ShowErrors) $display("%s", msg);
  endfunction

  function automatic logic [31:0] rand_duration();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(0, 3);
    if (pick < 96) return $urandom_range(4, 10);
    return $urandom;
  endfunction

  function automatic tss_req_t rand_req(logic [2:0] kind);
    tss_req_t r;
    r.req_type        = kind;
    r.frequency_hz    = 16'($urandom);
    r.duty_hundredths = ($urandom_range(0, 9) < 7) ? 14'($urandom_range(0, 10000))
                                                   : 14'($urandom);
    r.duration_ms     = rand_duration();
    r.note_slot       = 5'($urandom);
    r.note_count      = 6'($urandom);
    r.direction_up    = 1'($urandom);
    return r;
  endfunction

  function automatic tss_req_t mk_req(logic [2:0] kind, logic [15:0] freq, logic [13:0] hund,
                                      logic [31:0] dur, logic [4:0] slot, logic [5:0] cnt,
                                      logic up);
    tss_req_t r;
    r.req_type        = kind;
    r.frequency_hz    = freq;
    r.duty_hundredths = hund;
    r.duration_ms     = dur;
    r.note_slot       = slot;
    r.note_count      = cnt;
    r.direction_up    = up;
    return r;
  endfunction

  // one request transfer; prediction happens at the accepting edge
  task automatic send_req(tss_req_t r);
    tss_res_t want;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!req_if.ready);
    want = sequencer_step(r);
    drive_q.push_back(want);
    if (r.req_type <= REQ_STOP) items_sent++;
    if (want.status == ST_STARTED) begin
      if (seq_tone_on) tones_started++;
      else scales_started++;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_resolution(logic [4:0] bits);
    wait_idle();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= bits;
    do @(posedge clk); while (!cfg_if.ready);
    seq_res_bits = bits;
    res_settings++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // ticks until the tone or scale ends, mixed with note writes, starts, stops and noise
  task automatic play_out();
    int unsigned guard;
    int unsigned pick;
    guard = 0;
    while (seq_tone_on || seq_scale_on) begin
      pick = $urandom_range(0, 99);
      if (guard >= TickGuard || pick < 3) begin
        send_req(rand_req(REQ_STOP));
      end else if (pick < 9) begin
        send_req(rand_req(REQ_LOAD_NOTE));
      end else if (pick < 15) begin
        send_req(rand_req((pick < 11) ? REQ_START_SCALE : 3'($urandom_range(1, 2))));
      end else if (pick < 18) begin
        send_req(rand_req(3'($urandom_range(ReqUnusedLo, ReqUnusedHi))));
      end else begin
        send_req(rand_req(REQ_TICK));
      end
      guard++;
    end
  endtask

  task automatic random_episode();
    tss_req_t    r;
    int unsigned pick;
    int unsigned len_pick;
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      r = rand_req(REQ_TONE_DUTY);
    end else if (pick < 48) begin
      r = rand_req(REQ_TONE_HALF);
    end else if (pick < 78) begin
      r = rand_req(REQ_START_SCALE);
      len_pick = $urandom_range(0, 99);
      r.note_count = (len_pick < 3)  ? 6'd0 :
                     (len_pick < 83) ? 6'($urandom_range(1, 6)) :
                     (len_pick < 92) ? 6'($urandom_range(7, 31)) : 6'($urandom_range(32, 63));
      r.duration_ms = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 2);
    end else if (pick < 88) begin
      r = rand_req(REQ_LOAD_NOTE);
    end else begin
      r = rand_req(3'($urandom_range(0, 7)));
    end
    send_req(r);
    play_out();
  endtask

  task automatic test_note_table_fill();
    logic [15:0] freq;
    for (int s = 0; s < NoteSlots; s++) begin
      freq = (s == 0) ? 16'h0000 : (s == NoteSlots - 1) ? 16'hFFFF : 16'($urandom);
      send_req(mk_req(REQ_LOAD_NOTE, freq, '0, '0, 5'(s), '0, 1'b0));
    end
  endtask

  task automatic test_directed_cases();
    send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(REQ_STOP, '0, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(ReqUnusedLo, '1, '1, '1, '1, '1, 1'b1));
    send_req(mk_req(ReqUnusedHi, '1, '1, '1, '1, '1, 1'b1));
    // zero length ends on the first tick; busy rejects both starts
    send_req(mk_req(REQ_TONE_DUTY, 16'hFFFF, DutyFullScale, '0, '0, '0, 1'b0));
    send_req(mk_req(REQ_TONE_DUTY, 16'd440, 14'd5000, 32'd5, '0, '0, 1'b0));
    send_req(mk_req(REQ_START_SCALE, 16'd0, '0, 32'd1, '0, 6'd4, 1'b1));
    send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
    // duty above full scale saturates
    send_req(mk_req(REQ_TONE_DUTY, 16'd0, 14'h3FFF, 32'd1, '0, '0, 1'b0));
    send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(REQ_TONE_HALF, 16'd1234, '0, 32'hFFFF_FFFF, '0, '0, 1'b0));
    send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(REQ_STOP, '0, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(REQ_START_SCALE, 16'hFFFF, '0, 32'd3, '0, 6'd0, 1'b1));
    send_req(mk_req(REQ_START_SCALE, '0, '0, '0, '0, 6'd1, 1'b1));
    send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
    // full table downward, with a note rewritten while playing
    send_req(mk_req(REQ_START_SCALE, '0, '0, '0, '0, 6'd32, 1'b0));
    send_req(mk_req(REQ_LOAD_NOTE, 16'h5A5A, '0, '0, 5'd30, '0, 1'b0));
    send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(REQ_STOP, '0, '0, '0, '0, '0, 1'b0));
    // count over table size clamps
    send_req(mk_req(REQ_START_SCALE, '0, '0, 32'd1, '0, 6'd63, 1'b1));
    send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(REQ_STOP, '0, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(REQ_TONE_DUTY, 16'd440, 14'd0, 32'd3, '0, '0, 1'b0));
    send_req(mk_req(REQ_STOP, '0, '0, '0, '0, '0, 1'b0));
  endtask

  task automatic test_resolution_sweep();
    logic [4:0] setting [7] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd0, ResBitsReset};
    setting[5] = 5'($urandom_range(2, 15));
    foreach (setting[i]) begin
      write_resolution(setting[i]);
      send_req(mk_req(REQ_TONE_DUTY, 16'($urandom), DutyFullScale, '0, '0, '0, 1'b0));
      send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
      send_req(mk_req(REQ_TONE_DUTY, 16'($urandom), 14'($urandom_range(1, 9999)), '0, '0, '0,
                      1'b0));
      send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
      send_req(mk_req(REQ_TONE_HALF, 16'($urandom), '0, '0, '0, '0, 1'b0));
      send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
      send_req(mk_req(REQ_START_SCALE, '0, '0, '0, '0, 6'd1, 1'b0));
      send_req(mk_req(REQ_TICK, '0, '0, '0, '0, '0, 1'b0));
    end
  endtask

  task automatic test_random_traffic(int unsigned count, logic [4:0] bits,
                                     int unsigned src_pct, int unsigned dst_pct);
    int unsigned target;
    wait_idle();
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    write_resolution(bits);
    target = items_sent + count;
    while (items_sent < target) random_episode();
  endtask

  // result side holds off while requests keep coming, so the block backs up
  task automatic test_output_stall();
    int unsigned target;
    wait_idle();
    stall_left = StallLen;
    target = items_sent + 60;
    while (items_sent < target) random_episode();
    wait_idle();
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    tss_res_t want;
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      results_seen++;
      if (drive_q.size() == 0) begin
        log_failure($sformatf("unexpected result %p", res_if.data));
      end else begin
        want = drive_q.pop_front();
        if (res_if.data !== want) begin
          log_failure($sformatf({"result %0d mismatch: expected freq %0d duty %0d tone %0b ",
                                 "scale %0b note %0d status %0d, got freq %0d duty %0d ",
                                 "tone %0b scale %0b note %0d status %0d"},
                                results_seen, want.out_frequency, want.out_duty,
                                want.tone_busy, want.scale_busy, want.current_note,
                                want.status, res_if.data.out_frequency, res_if.data.out_duty,
                                res_if.data.tone_busy, res_if.data.scale_busy,
                                res_if.data.current_note, res_if.data.status));
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    res_if.ready = 1'b0;
    rst_n        = 1'b0;
    src_idle_pct = 20;
    dst_idle_pct = 57;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_note_table_fill();
    test_directed_cases();
    test_resolution_sweep();
    test_random_traffic(500, 5'($urandom_range(1, 16)), 20, 57);
    test_output_stall();
    test_random_traffic(500, 5'($urandom), 57, 20);
    test_random_traffic(500, ResBitsReset, 0, 0);

    wait_idle();
    repeat (8) @(posedge clk);
    errors += drive_q.size();

    $display("Covered %0d requests and %0d checked results over %0d resolution settings,",
             items_sent, results_seen, res_settings);
    $display("with %0d tones and %0d scales started; %0d mismatches.",
             tones_started, scales_started, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
